// ----- src/raw_pkg.sv -----
// ----------------------------------------------------------------------------
// raw_pkg - shared types and constants of the read-ahead window ring
// Item layouts of both channels, request codes and parameter defaults.
// ----------------------------------------------------------------------------
package raw_pkg;

    localparam int RING_BYTES_DEF = 16384;
    localparam int MAX_READ_DEF   = 64;
    localparam int FREE_W         = 15;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_FILL   = 2'd1;
    localparam logic [1:0] REQ_REBASE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] req_pos;
        logic [6:0]  req_count;
        logic [7:0]  fill_byte;
        logic [31:0] fill_gen;
    } raw_req_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              last;
        logic              read_miss;
        logic              fill_taken;
        logic [31:0]       refill_pos;
        logic [FREE_W-1:0] free_space;
        logic [31:0]       window_gen;
    } raw_rsp_t;

    // Room left in the output queue once this cycle's pop is counted
    typedef struct packed {
        logic one;
        logic two;
    } raw_room_t;

endpackage

// ----- src/raw_ram.sv -----
// ----------------------------------------------------------------------------
// raw_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module raw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/raw_obuf.sv -----
// ----------------------------------------------------------------------------
// raw_obuf - two-entry output queue
// Holds result items while the receiver stalls and reports free room.
// ----------------------------------------------------------------------------
module raw_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  raw_pkg::raw_rsp_t push_data,
    output raw_pkg::raw_room_t room,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output raw_pkg::raw_rsp_t rsp
);
    import raw_pkg::*;

    raw_rsp_t   entry_reg [2];
    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       pop;
    logic [1:0] avail;

    assign rsp_valid = (occ_reg != 2'd0);
    assign rsp       = entry_reg[rd_ptr_reg];
    assign pop       = rsp_valid && !rsp_stall;
    assign avail     = occ_reg - {1'b0, pop};
    assign room.one  = (avail != 2'd2);
    assign room.two  = (avail == 2'd0);

    always_comb
    begin
        occ_next = avail + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/raw_ctrl.sv -----
// ----------------------------------------------------------------------------
// raw_ctrl - window sequencer
// Holds the window registers, classifies each item, writes fill bytes to the
// ring and streams served bytes out of it one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module raw_ctrl #(
    parameter int RING_BYTES = raw_pkg::RING_BYTES_DEF,
    parameter int MAX_READ   = raw_pkg::MAX_READ_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  raw_pkg::raw_req_t             req,
    input  logic                          prefetch_en,
    input  logic [31:0]                   data_length,
    input  raw_pkg::raw_room_t            room,
    output logic                          push,
    output raw_pkg::raw_rsp_t             push_data,
    output logic                          mem_we,
    output logic [$clog2(RING_BYTES)-1:0] mem_waddr,
    output logic [7:0]                    mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(RING_BYTES)-1:0] mem_raddr,
    input  logic [7:0]                    mem_rdata
);
    import raw_pkg::*;

    localparam int PW    = $clog2(RING_BYTES);
    localparam int VC_W  = $clog2(RING_BYTES + 1);
    localparam int SUM_W = VC_W + 1;
    localparam int CNT_W = $clog2(MAX_READ + 1);
    localparam int CMP_W = (VC_W > 7) ? VC_W : 7;
    localparam int FS_W  = (VC_W > FREE_W) ? VC_W : FREE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_SETUP = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PW-1:0]    rp_reg, rp_next;
    logic [VC_W-1:0]  vc_reg, vc_next;
    logic [31:0]      wend_reg, wend_next;
    logic [31:0]      gen_reg, gen_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             inflight_reg, inflight_next;
    logic             infl_last_reg, infl_last_next;
    raw_req_t         req_reg, req_next;
    logic [VC_W-1:0]  d_reg, d_next;
    logic [VC_W-1:0]  skip_reg, skip_next;

    logic [31:0]      d_full;
    logic             hit;
    logic             fill_ok;
    logic [VC_W-1:0]  add_b;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wsum;
    logic [PW-1:0]    wrap_addr;
    logic [PW-1:0]    rp_inc;
    logic [6:0]       cnt_sat;
    logic [CMP_W-1:0] served_w;
    logic [FS_W-1:0]  free_w;
    logic             st_push;
    logic             st_miss;
    logic             st_taken;

    // Window hit: distance from position to window end lies in 1..valid_count
    assign d_full  = wend_reg - req_reg.req_pos;
    assign hit     = (vc_reg != '0) && (d_full != 32'd0) && (d_full <= 32'(vc_reg));
    assign fill_ok = prefetch_en && (data_length != 32'd0)
                     && (req_reg.fill_gen == gen_reg)
                     && (vc_reg < VC_W'(RING_BYTES))
                     && (wend_reg < data_length);

    // Shared ring-index adder: write slot on a fill, skip on a read hit
    assign add_b     = (state_reg == ST_SETUP) ? skip_reg : vc_reg;
    assign sum       = SUM_W'(rp_reg) + SUM_W'(add_b);
    assign wsum      = (sum >= SUM_W'(RING_BYTES)) ? sum - SUM_W'(RING_BYTES) : sum;
    assign wrap_addr = wsum[PW-1:0];
    assign rp_inc    = (rp_reg == PW'(RING_BYTES - 1)) ? '0 : rp_reg + PW'(1);

    assign cnt_sat  = (req_reg.req_count > 7'(MAX_READ)) ? 7'(MAX_READ)
                                                          : req_reg.req_count;
    assign served_w = (CMP_W'(cnt_sat) <= CMP_W'(d_reg)) ? CMP_W'(cnt_sat)
                                                          : CMP_W'(d_reg);

    assign req_stall = (state_reg != ST_IDLE) || inflight_reg;

    assign mem_waddr = wrap_addr;
    assign mem_wdata = req_reg.fill_byte;
    assign mem_raddr = rp_reg;

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        vc_next        = vc_reg;
        wend_next      = wend_reg;
        gen_next       = gen_reg;
        cnt_next       = cnt_reg;
        inflight_next  = 1'b0;
        infl_last_next = infl_last_reg;
        req_next       = req_reg;
        d_next         = d_reg;
        skip_next      = skip_reg;
        st_push        = 1'b0;
        st_miss        = 1'b0;
        st_taken       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    req_next   = req;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                d_next    = d_full[VC_W-1:0];
                skip_next = vc_reg - d_full[VC_W-1:0];
                if (room.one)
                begin
                    state_next = ST_IDLE;
                    st_push    = 1'b1;
                    case (req_reg.req_type)
                        REQ_READ:
                        begin
                            if (req_reg.req_count == 7'd0)
                            begin
                                st_push = 1'b1;
                            end
                            else if (hit)
                            begin
                                st_push    = 1'b0;
                                state_next = ST_SETUP;
                            end
                            else
                            begin
                                st_miss   = 1'b1;
                                rp_next   = '0;
                                vc_next   = '0;
                                wend_next = req_reg.req_pos;
                                gen_next  = gen_reg + 32'd1;
                            end
                        end
                        REQ_FILL:
                        begin
                            if (fill_ok)
                            begin
                                mem_we    = 1'b1;
                                st_taken  = 1'b1;
                                vc_next   = vc_reg + VC_W'(1);
                                wend_next = wend_reg + 32'd1;
                            end
                        end
                        REQ_REBASE:
                        begin
                            rp_next   = '0;
                            vc_next   = '0;
                            wend_next = req_reg.req_pos;
                            gen_next  = gen_reg + 32'd1;
                        end
                        default:
                        begin
                            st_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                // drop the skipped bytes and reserve the served ones
                rp_next    = wrap_addr;
                vc_next    = d_reg - served_w[VC_W-1:0];
                cnt_next   = served_w[CNT_W-1:0];
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (inflight_reg ? room.two : room.one)
                begin
                    mem_re         = 1'b1;
                    rp_next        = rp_inc;
                    cnt_next       = cnt_reg - CNT_W'(1);
                    inflight_next  = 1'b1;
                    infl_last_next = (cnt_reg == CNT_W'(1));
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result fields always show the window after the current edge
    assign free_w = FS_W'(RING_BYTES) - FS_W'(vc_next);
    assign push   = inflight_reg || st_push;

    always_comb
    begin
        push_data.out_byte   = inflight_reg ? mem_rdata : 8'd0;
        push_data.byte_valid = inflight_reg;
        push_data.last       = inflight_reg ? infl_last_reg : 1'b1;
        push_data.read_miss  = st_miss;
        push_data.fill_taken = st_taken;
        push_data.refill_pos = wend_next;
        push_data.free_space = free_w[FREE_W-1:0];
        push_data.window_gen = gen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            vc_reg        <= '0;
            wend_reg      <= 32'd0;
            gen_reg       <= 32'd0;
            cnt_reg       <= '0;
            inflight_reg  <= 1'b0;
            infl_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            vc_reg        <= vc_next;
            wend_reg      <= wend_next;
            gen_reg       <= gen_next;
            cnt_reg       <= cnt_next;
            inflight_reg  <= inflight_next;
            infl_last_reg <= infl_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        d_reg    <= d_next;
        skip_reg <= skip_next;
    end

endmodule

// ----- src/read_ahead_window_ring.sv -----
// ----------------------------------------------------------------------------
// read_ahead_window_ring - read-ahead window over a byte ring
// Sliding file window with fill, read and rebase items and APB registers.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    raw_req_t
//  rsp      out        rsp_valid/stall    raw_rsp_t
//  apb      in/out     psel/penable/...   prdata, pwdata (32 bits)
//
//  A fill, rebase, miss or empty read is accepted, then evaluated; a read hit
//  is accepted, evaluated and set up, then streams N served bytes (up to
//  MAX_READ), one per cycle while the queue has room (single RAM read port).
//  Reset clears the window registers at once; ring contents are not cleared.
//  Results pass through a two-entry queue; byte reads wait while it has no room.
// ----------------------------------------------------------------------------
module read_ahead_window_ring #(
    parameter int RING_BYTES = raw_pkg::RING_BYTES_DEF,
    parameter int MAX_READ   = raw_pkg::MAX_READ_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  raw_pkg::raw_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output raw_pkg::raw_rsp_t rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import raw_pkg::*;

    localparam int PW = $clog2(RING_BYTES);

    localparam logic REG_PREFETCH = 1'b0;
    localparam logic REG_LENGTH   = 1'b1;

    logic        prefetch_en_reg;
    logic [31:0] data_length_reg;
    logic        cfg_wr;

    raw_room_t   room;
    logic        push;
    raw_rsp_t    push_data;
    logic        mem_we;
    logic [PW-1:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_re;
    logic [PW-1:0] mem_raddr;
    logic [7:0]  mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_PREFETCH: prdata = {31'd0, prefetch_en_reg};
            REG_LENGTH:   prdata = data_length_reg;
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefetch_en_reg <= 1'b0;
            data_length_reg <= 32'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PREFETCH)
            begin
                prefetch_en_reg <= pwdata[0];
            end
            else
            begin
                data_length_reg <= pwdata;
            end
        end
    end

    raw_ctrl #(
        .RING_BYTES (RING_BYTES),
        .MAX_READ   (MAX_READ)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .prefetch_en (prefetch_en_reg),
        .data_length (data_length_reg),
        .room        (room),
        .push        (push),
        .push_data   (push_data),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    raw_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    raw_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .room      (room),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
